// ----- rtl/lfu_cache_table_unit_macros.svh -----
// Assertion macros shared by the cache table checker.
`ifndef LFU_CACHE_TABLE_UNIT_MACROS_SVH
`define LFU_CACHE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("lfu check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lfu check failed: next-cycle rule");

`endif

// ----- rtl/lfu_pkg.sv -----
// Shared constants and controller/datapath interface types for the LFU cache table.
package lfu_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int DATA_W  = 32;
	localparam int USE_W   = 16;
	localparam int STAMP_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [USE_W-1:0] USE_MAX   = '1;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ENTRIES - 1);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} lfu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} lfu_sts_t;

endpackage

// ----- rtl/lfu_ctrl.sv -----
// Sequencer: accepts an item, steps the entry scan, then commits the result.
module lfu_ctrl
	import lfu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  lfu_sts_t sts,
	output lfu_cmd_t cmd_o
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd_o = '0;
		unique case (state_q)
			ST_IDLE:   cmd_o.load   = in_valid;
			ST_SCAN:   cmd_o.step   = 1'b1;
			ST_COMMIT: cmd_o.commit = sts.out_free;
			default:   cmd_o = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/lfu_dp.sv -----
// Entry store, scan accumulators, commit logic and result register.
module lfu_dp
	import lfu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  lfu_cmd_t                 cmd_i,
	output lfu_sts_t                 sts,
	input  logic                     cfg_we,
	input  logic [CAP_W-1:0]         cfg_data,
	input  logic                     cmd,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value,
	output logic                     evicted
);

	// entry store
	logic [ENTRIES-1:0]       valid_q;
	logic [DATA_W-1:0]        key_mem_q   [ENTRIES];
	logic [DATA_W-1:0]        val_mem_q   [ENTRIES];
	logic [USE_W-1:0]         use_mem_q   [ENTRIES];
	logic [STAMP_W-1:0]       stamp_mem_q [ENTRIES];
	logic [STAMP_W-1:0]       stamp_q;
	logic [CAP_W-1:0]         capacity_q;

	// item held during the scan
	logic                     cmd_q;
	logic [DATA_W-1:0]        key_q;
	logic [DATA_W-1:0]        value_q;
	logic [IDX_W-1:0]         idx_q;

	// scan accumulators
	logic                     match_q;
	logic [IDX_W-1:0]         match_idx_q;
	logic [DATA_W-1:0]        match_val_q;
	logic [USE_W-1:0]         match_use_q;
	logic [CNT_W-1:0]         used_q;
	logic                     free_q;
	logic [IDX_W-1:0]         free_idx_q;
	logic                     vic_q;
	logic [IDX_W-1:0]         vic_idx_q;
	logic [USE_W-1:0]         vic_use_q;
	logic [STAMP_W-1:0]       vic_age_q;

	logic                     out_valid_q;
	logic                     hit_q;
	logic [DATA_W-1:0]        rd_q;
	logic                     ev_q;

	// current scan entry
	logic                     rd_vld;
	logic [USE_W-1:0]         rd_use;
	logic [STAMP_W-1:0]       rd_age;
	logic                     better;

	// commit decision
	logic [CMP_W-1:0]         cap_ext;
	logic [CMP_W-1:0]         cap_lim;
	logic                     cap_nz;
	logic                     is_put;
	logic                     do_evict;
	logic                     do_insert;
	logic                     do_touch;
	logic                     do_vwrite;
	logic [IDX_W-1:0]         ins_idx;
	logic [USE_W-1:0]         use_inc;

	assign rd_vld = valid_q[idx_q];
	assign rd_use = use_mem_q[idx_q];
	assign rd_age = stamp_q - stamp_mem_q[idx_q];
	assign better = !vic_q || (rd_use < vic_use_q) ||
			((rd_use == vic_use_q) && (rd_age > vic_age_q));

	assign cap_ext   = CMP_W'(capacity_q);
	assign cap_lim   = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
	assign cap_nz    = (cap_lim != '0);
	assign is_put    = (cmd_q == CMD_PUT);
	assign do_evict  = is_put && cap_nz && !match_q && vic_q &&
			(CMP_W'(used_q) >= cap_lim);
	assign do_insert = is_put && cap_nz && !match_q && (do_evict || free_q);
	assign do_touch  = match_q && (!is_put || cap_nz);
	assign do_vwrite = match_q && is_put && cap_nz;
	assign ins_idx   = do_evict ? vic_idx_q : free_idx_q;
	assign use_inc   = (match_use_q == USE_MAX) ? match_use_q : match_use_q + 1'b1;

	assign sts.scan_last = (idx_q == IDX_LAST);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rd_q;
	assign evicted    = ev_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			stamp_q     <= '0;
			capacity_q  <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) capacity_q <= cfg_data;
			if (cmd_i.commit && do_insert) valid_q[ins_idx] <= 1'b1;
			if (cmd_i.commit && (do_touch || do_insert)) stamp_q <= stamp_q + 1'b1;
			if (cmd_i.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// entry payload, written once per item at one slot
	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			if (do_insert) begin
				key_mem_q[ins_idx]   <= key_q;
				val_mem_q[ins_idx]   <= value_q;
				use_mem_q[ins_idx]   <= USE_W'(1);
				stamp_mem_q[ins_idx] <= stamp_q;
			end else if (do_touch) begin
				use_mem_q[match_idx_q]   <= use_inc;
				stamp_mem_q[match_idx_q] <= stamp_q;
				if (do_vwrite) val_mem_q[match_idx_q] <= value_q;
			end
		end
	end

	// item capture and scan, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			vic_q   <= 1'b0;
			used_q  <= '0;
		end else if (cmd_i.load) begin
			idx_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			vic_q   <= 1'b0;
			used_q  <= '0;
		end else if (cmd_i.step) begin
			idx_q <= sts.scan_last ? '0 : idx_q + 1'b1;
			if (rd_vld) begin
				used_q <= used_q + 1'b1;
				if (!match_q && (key_mem_q[idx_q] == key_q)) match_q <= 1'b1;
				if (better) vic_q <= 1'b1;
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q   <= cmd;
			key_q   <= key;
			value_q <= value;
		end
		if (cmd_i.step) begin
			if (rd_vld) begin
				if (!match_q && (key_mem_q[idx_q] == key_q)) begin
					match_idx_q <= idx_q;
					match_val_q <= val_mem_q[idx_q];
					match_use_q <= rd_use;
				end
				if (better) begin
					vic_idx_q <= idx_q;
					vic_use_q <= rd_use;
					vic_age_q <= rd_age;
				end
			end else if (!free_q) begin
				free_idx_q <= idx_q;
			end
		end
		if (cmd_i.commit) begin
			hit_q <= match_q;
			ev_q  <= do_evict;
			if (is_put) begin
				rd_q <= '0;
			end else if (match_q) begin
				rd_q <= match_val_q;
			end else begin
				rd_q <= '1;
			end
		end
	end

endmodule

// ----- rtl/lfu_cache_table_unit.sv -----
// Top level of the LFU key/value cache table.
//
//  channel | handshake             | beat
//  in      | in_valid / in_stall   | cmd, key, value
//  out     | out_valid / out_stall | hit, read_value, evicted
//  cfg     | cfg_valid / cfg_ready | cfg_data (capacity)
//
// An item passes through accept, a scan of the table slots, one slot per cycle, for
// the key match and victim scan, then a commit writing the chosen slot.
// The result register frees the scan: a new beat is taken while a result waits;
// commit holds only if the previous result is still stalled.
// Reset clears valid bits, stamp counter and sets capacity to 16; no clearing pass.
module lfu_cache_table_unit
	import lfu_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value,
	output logic                     evicted,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CAP_W-1:0]         cfg_data
);

	lfu_cmd_t cmd_w;
	lfu_sts_t sts_w;

	assign cfg_ready = 1'b1;

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts_w),
		.cmd_o    (cmd_w)
	);

	lfu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_i      (cmd_w),
		.sts        (sts_w),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted)
	);

endmodule

// ----- rtl/lfu_checker.sv -----
// Port-level checks on the LFU cache table, bound to the top level.
`include "lfu_cache_table_unit_macros.svh"

module lfu_checker
	import lfu_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic                     hit,
	input logic signed [DATA_W-1:0] read_value,
	input logic                     evicted
);

	// a stalled result beat stays offered
	`LFU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// one item at a time: the beat after an accepted one is stalled
	`LFU_ASSERT_NEXT(a_in_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// eviction only on a put of a new key, which reads back zero
	`LFU_ASSERT_NOW(a_evict_put, clk, arst_n, out_valid && evicted,
		!hit && (read_value == '0))
	// a miss reads zero (put) or all ones (get)
	`LFU_ASSERT_NOW(a_miss_value, clk, arst_n, out_valid && !hit && (read_value != '0),
		(read_value == '1) && !evicted)

endmodule

bind lfu_cache_table_unit lfu_checker u_lfu_checker (.*);

// ----- tb/tb_lfu_cache_table_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LFU cache table: directed and random gets and puts against a cycle-free predictor.
module tb_lfu_cache_table_unit;
	import lfu_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_CYCLES = ENTRIES + 2;
	localparam int PHASE_ITEMS  = 195;
	localparam int POOL_DEPTH   = 32;
	localparam int OP_SLOTS     = 4096;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic              cmd;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} cache_op_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
	} cache_resp_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic                     cmd        = CMD_GET;
	logic signed [DATA_W-1:0] key        = '0;
	logic signed [DATA_W-1:0] value      = '0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;
	logic                     evicted;
	logic                     cfg_valid  = 1'b0;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data   = '0;

	// shadow copy of the table
	logic               slot_live  [ENTRIES];
	logic [DATA_W-1:0]  slot_key   [ENTRIES];
	logic [DATA_W-1:0]  slot_val   [ENTRIES];
	logic [USE_W-1:0]   slot_uses  [ENTRIES];
	logic [STAMP_W-1:0] slot_stamp [ENTRIES];
	logic [STAMP_W-1:0] stamp_now;
	logic [CAP_W-1:0]   capacity_now;

	// pending items and expected results, each a ring with write and read counts
	cache_op_t   pending_ops   [OP_SLOTS];
	cache_resp_t expected_resp [OP_SLOTS];
	int          pend_wr = 0;
	int          pend_rd = 0;
	int          exp_wr  = 0;
	int          exp_rd  = 0;
	cache_op_t   offered_op;
	cache_resp_t next_resp;

	int ops_queued   = 0;
	int ops_taken    = 0;
	int results_seen = 0;
	int error_count  = 0;
	int cycle_count  = 0;
	int send_gap     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	int hold_clock   = 0;

	always #2 clk = ~clk;

	lfu_cache_table_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	function automatic void touch_slot(int idx, bit raise);
		if (raise && slot_uses[idx] != USE_MAX)
			slot_uses[idx] = slot_uses[idx] + 1'b1;
		slot_stamp[idx] = stamp_now;
		stamp_now = stamp_now + 1'b1;
	endfunction

	function automatic cache_resp_t apply_cache_op(cache_op_t op);
		cache_resp_t        r;
		int                 found;
		int                 free_idx;
		int                 victim;
		int                 used;
		int                 eff;
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] best_age;
		logic [USE_W-1:0]   best_cnt;
		r = '0;
		found = -1;
		free_idx = -1;
		victim = -1;
		used = 0;
		best_age = '0;
		best_cnt = '0;
		eff = (int'(capacity_now) < ENTRIES) ? int'(capacity_now) : ENTRIES;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && slot_live[i] && slot_key[i] == op.key)
				found = i;
		r.hit = (found >= 0);
		if (op.cmd == CMD_GET) begin
			if (found >= 0) begin
				r.read_value = slot_val[found];
				touch_slot(found, 1'b1);
			end else begin
				r.read_value = '1;
			end
		end else if (eff != 0) begin
			if (found >= 0) begin
				slot_val[found] = op.value;
				touch_slot(found, 1'b1);
			end else begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_live[i])
						used++;
					else if (free_idx < 0)
						free_idx = i;
				end
				if (used >= eff) begin
					// lowest count wins, then the oldest touch, then the lowest slot
					for (int i = 0; i < ENTRIES; i++) begin
						if (slot_live[i]) begin
							age = stamp_now - slot_stamp[i];
							if (victim < 0 || slot_uses[i] < best_cnt ||
							    (slot_uses[i] == best_cnt && age > best_age)) begin
								victim = i;
								best_cnt = slot_uses[i];
								best_age = age;
							end
						end
					end
					if (victim >= 0) begin
						slot_live[victim] = 1'b0;
						r.evicted = 1'b1;
						free_idx = victim;
					end
				end
				if (free_idx >= 0) begin
					slot_live[free_idx] = 1'b1;
					slot_key[free_idx] = op.key;
					slot_val[free_idx] = op.value;
					slot_uses[free_idx] = USE_W'(1);
					touch_slot(free_idx, 1'b0);
				end
			end
		end
		return r;
	endfunction

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_resp[exp_wr % OP_SLOTS] = apply_cache_op(offered_op);
				exp_wr++;
				ops_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pend_rd != pend_wr) begin
					offered_op = pending_ops[pend_rd % OP_SLOTS];
					pend_rd++;
					in_valid <= 1'b1;
					cmd <= offered_op.cmd;
					key <= offered_op.key;
					value <= offered_op.value;
					// every fourth stretch of beats goes back to back
					send_gap = (((ops_taken / 50) % 4) == 3) ? 0 : $urandom_range(0, 6);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long back-pressure so the block fills and stalls its input
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_clock <= 0;
		end else begin
			hold_clock <= hold_clock + 1;
			if (hold_left > 0)
				hold_left <= hold_left - 1;
			else if (hold_clock == 3000 || hold_clock == 25000)
				hold_left <= HOLD_CYCLES;
		end
	end

	// result monitor and stall generator
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (exp_rd == exp_wr) begin
					$error("result beat with nothing expected: hit %0d read_value %0d evicted %0d",
						hit, read_value, evicted);
					error_count++;
				end else begin
					next_resp = expected_resp[exp_rd % OP_SLOTS];
					exp_rd++;
					if (hit !== next_resp.hit) begin
						$error("hit: expected %0d, actual %0d", next_resp.hit, hit);
						error_count++;
					end
					if (read_value !== next_resp.read_value) begin
						$error("read_value: expected %0d, actual %0d",
							$signed(next_resp.read_value), read_value);
						error_count++;
					end
					if (evicted !== next_resp.evicted) begin
						$error("evicted: expected %0d, actual %0d", next_resp.evicted, evicted);
						error_count++;
					end
				end
				results_seen++;
				stall_left = (((results_seen / 40) % 3) == 2) ? 0 : $urandom_range(0, 6);
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic push_op(input logic op_cmd, input logic [DATA_W-1:0] op_key,
		input logic [DATA_W-1:0] op_val);
		cache_op_t op;
		op.cmd = op_cmd;
		op.key = op_key;
		op.value = op_val;
		pending_ops[pend_wr % OP_SLOTS] = op;
		pend_wr++;
		ops_queued++;
	endtask

	task automatic wait_drained();
		while (ops_taken != ops_queued || exp_rd != exp_wr)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_data <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity_now = cap;
	endtask

	initial begin
		logic [DATA_W-1:0] key_pool [POOL_DEPTH];
		logic [DATA_W-1:0] k;
		int                phase_caps [10];
		int                eff;
		int                pool_size;
		int                roll;
		phase_caps = '{4, 31, 1, 2, 17, 0, 3, 8, 16, 5};
		for (int i = 0; i < ENTRIES; i++) begin
			slot_live[i] = 1'b0;
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_uses[i] = '0;
			slot_stamp[i] = '0;
		end
		stamp_now = '0;
		capacity_now = CAP_RESET;
		for (int i = 0; i < POOL_DEPTH; i++)
			key_pool[i] = $urandom;
		key_pool[1] = 32'h8000_0000;
		key_pool[2] = 32'h7FFF_FFFF;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, hits, update, fill to full and one eviction
		push_op(CMD_GET, 32'h0, 32'h0);
		push_op(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		push_op(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		push_op(CMD_PUT, 32'h0, 32'hFFFF_FFFF);
		push_op(CMD_PUT, 32'hFFFF_FFFF, 32'h0);
		push_op(CMD_GET, 32'h8000_0000, 32'h0);
		push_op(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push_op(CMD_GET, 32'hFFFF_FFFF, 32'h0);
		push_op(CMD_PUT, 32'h0, 32'h5555_AAAA);
		for (int i = 1; i <= 12; i++)
			push_op(CMD_PUT, i, ~i);
		// table full: key 1 has the lowest count and the oldest touch
		push_op(CMD_PUT, 32'h1234_5678, 32'h1);
		push_op(CMD_GET, 32'h1, 32'h0);
		wait_drained();

		// storing disabled: puts leave the table alone, gets still hit
		write_capacity(CAP_W'(0));
		push_op(CMD_PUT, 32'h0BAD_F00D, 32'h7);
		push_op(CMD_PUT, 32'h0, 32'h9);
		push_op(CMD_GET, 32'h0, 32'h0);
		wait_drained();

		foreach (phase_caps[p]) begin
			write_capacity(CAP_W'(phase_caps[p]));
			eff = (phase_caps[p] < ENTRIES) ? phase_caps[p] : ENTRIES;
			pool_size = eff + 2 + $urandom_range(0, 4);
			// keep most of the pool so earlier entries still get hit
			for (int i = 0; i < 4; i++)
				key_pool[$urandom_range(3, POOL_DEPTH - 1)] = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85)
					k = key_pool[$urandom_range(0, pool_size - 1)];
				else if (roll < 90)
					k = (roll & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				else
					k = $urandom;
				push_op(($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET, k, $urandom);
			end
			wait_drained();
		end

		if (error_count == 0 && exp_rd == exp_wr)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
